// ===== src/htmlcr_pkg.sv =====
// Shared types, constants, name table and character helpers of the HTML character reference decoder.
package htmlcr_pkg;

	localparam int WIN_BYTES  = 11;
	localparam int SCAN_LIMIT = 12;
	localparam int NUM_NAMES  = 19;
	localparam int KEY_BYTES  = 6;
	localparam int NUM_DIGITS = 9;
	localparam int SEG_DIGITS = 5;

	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 48;

	localparam logic [31:0] CP_LIMIT = 32'h0011_0000;
	localparam logic [31:0] CP_2B    = 32'h0000_0080;
	localparam logic [31:0] CP_3B    = 32'h0000_0800;
	localparam logic [31:0] CP_4B    = 32'h0001_0000;

	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X_LO = 8'h78;
	localparam logic [7:0] CH_X_UP = 8'h58;

	typedef enum logic [1:0] {
		ACT_LITERAL = 2'd0,
		ACT_DECODED = 2'd1,
		ACT_RAW     = 2'd2
	} action_t;

	typedef struct packed {
		logic [47:0] key;
		logic [2:0]  klen;
		logic [23:0] utf;
		logic [2:0]  nbytes;
	} name_entry_t;

	// Keys hold their first character in the lowest byte.
	localparam name_entry_t NAME_TABLE [NUM_NAMES] = '{
		'{48'h0000_0000_746C, 3'd2, 24'h00_003C, 3'd1},
		'{48'h0000_0000_7467, 3'd2, 24'h00_003E, 3'd1},
		'{48'h0000_0070_6D61, 3'd3, 24'h00_0026, 3'd1},
		'{48'h0000_746F_7571, 3'd4, 24'h00_0022, 3'd1},
		'{48'h0000_736F_7061, 3'd4, 24'h00_0027, 3'd1},
		'{48'h0000_7073_626E, 3'd4, 24'h00_A0C2, 3'd2},
		'{48'h0068_7361_646E, 3'd5, 24'h93_80E2, 3'd3},
		'{48'h0068_7361_646D, 3'd5, 24'h94_80E2, 3'd3},
		'{48'h006F_7571_616C, 3'd5, 24'h00_ABC2, 3'd2},
		'{48'h006F_7571_6172, 3'd5, 24'h00_BBC2, 3'd2},
		'{48'h0000_7970_6F63, 3'd4, 24'h00_A9C2, 3'd2},
		'{48'h0000_0067_6572, 3'd3, 24'h00_AEC2, 3'd2},
		'{48'h0065_6461_7274, 3'd5, 24'hA2_84E2, 3'd3},
		'{48'h7069_6C6C_6568, 3'd6, 24'hA6_80E2, 3'd3},
		'{48'h0000_6C6C_7562, 3'd4, 24'hA2_80E2, 3'd3},
		'{48'h006F_7571_7372, 3'd5, 24'h99_80E2, 3'd3},
		'{48'h006F_7571_736C, 3'd5, 24'h98_80E2, 3'd3},
		'{48'h006F_7571_6472, 3'd5, 24'h9D_80E2, 3'd3},
		'{48'h006F_7571_646C, 3'd5, 24'h9C_80E2, 3'd3}
	};

	typedef struct packed {
		logic                         found;
		logic                         numeric;
		logic                         hex;
		logic                         name_hit;
		logic [3:0]                   consumed;
		logic [23:0]                  name_utf;
		logic [2:0]                   name_cnt;
		logic [NUM_DIGITS-1:0]        active;
		logic [NUM_DIGITS-1:0][3:0]   digits;
	} scan_t;

	typedef struct packed {
		action_t     action;
		logic [3:0]  consumed;
		logic [2:0]  out_count;
		logic [31:0] out_bytes;
	} result_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		if (is_dec(c)) begin
			t = c - 8'h30;
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			t = c - 8'h57;
		end else begin
			t = c - 8'h37;
		end
		return t[3:0];
	endfunction

endpackage

// ===== src/htmlcr_scan.sv =====
// Window classification: semicolon search, numeric digit run and named reference match.
module htmlcr_scan import htmlcr_pkg::*; (
	input  logic [63:0] window_low,
	input  logic [23:0] window_high,
	input  logic [3:0]  avail,
	output scan_t       scan
);

	logic [7:0] wb [1:WIN_BYTES];
	logic [3:0] av;
	logic [3:0] pos;
	logic       found;
	logic       hex;
	logic       run;
	logic       ok;
	logic       hit;
	logic       m;
	logic [23:0] utf;
	logic [2:0]  cnt;

	always_comb begin
		for (int j = 1; j <= 8; j++) begin
			wb[j] = window_low[8*(j-1) +: 8];
		end
		for (int j = 9; j <= WIN_BYTES; j++) begin
			wb[j] = window_high[8*(j-9) +: 8];
		end

		av = (avail > 4'(WIN_BYTES)) ? 4'(WIN_BYTES) : avail;

		// Scan downwards so that the first semicolon wins.
		found = 1'b0;
		pos   = 4'd0;
		for (int j = WIN_BYTES; j >= 1; j--) begin
			if ((wb[j] == CH_SEMI) && (j <= int'(av)) && (j < SCAN_LIMIT)) begin
				found = 1'b1;
				pos   = 4'(j);
			end
		end

		hex = (wb[2] == CH_X_LO) || (wb[2] == CH_X_UP);

		// Digit k sits at window position k+2; a hex run starts one later.
		run = 1'b1;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			ok = hex ? is_hex(wb[k+2]) : is_dec(wb[k+2]);
			scan.digits[k] = hex_val(wb[k+2]);
			if (hex && (k == 0)) begin
				scan.active[k] = 1'b0;
			end else begin
				run = run & ok;
				scan.active[k] = run;
			end
		end

		// A key matches when its bytes agree and a semicolon follows it inside the valid bytes.
		hit = 1'b0;
		utf = 24'd0;
		cnt = 3'd0;
		for (int e = 0; e < NUM_NAMES; e++) begin
			m = (wb[int'(NAME_TABLE[e].klen) + 1] == CH_SEMI)
				&& (int'(NAME_TABLE[e].klen) + 1 <= int'(av));
			for (int b = 0; b < KEY_BYTES; b++) begin
				if (b < int'(NAME_TABLE[e].klen)) begin
					m = m && (wb[b+1] == NAME_TABLE[e].key[8*b +: 8]);
				end
			end
			if (m) begin
				hit = 1'b1;
				utf = utf | NAME_TABLE[e].utf;
				cnt = cnt | NAME_TABLE[e].nbytes;
			end
		end

		scan.found    = found;
		scan.numeric  = found && (pos >= 4'd3) && (wb[1] == CH_HASH);
		scan.hex      = hex;
		scan.name_hit = hit;
		scan.consumed = pos + 4'd1;
		scan.name_utf = utf;
		scan.name_cnt = cnt;
	end

endmodule

// ===== src/htmlcr_accum.sv =====
// One segment of the numeric accumulator: folds up to five digits into the code point.
module htmlcr_accum import htmlcr_pkg::*; (
	input  logic                         hex,
	input  logic [31:0]                  acc_in,
	input  logic [SEG_DIGITS-1:0][3:0]   digits,
	input  logic [SEG_DIGITS-1:0]        active,
	output logic [31:0]                  acc_out
);

	logic [31:0] acc;

	always_comb begin
		acc = acc_in;
		for (int k = 0; k < SEG_DIGITS; k++) begin
			if (active[k]) begin
				if (hex) begin
					acc = {acc[27:0], digits[k]};
				end else begin
					acc = (acc << 3) + (acc << 1) + {28'd0, digits[k]};
				end
			end
		end
		acc_out = acc;
	end

endmodule

// ===== src/htmlcr_encode.sv =====
// UTF-8 encoding of the code point and selection of the final result.
module htmlcr_encode import htmlcr_pkg::*; (
	input  scan_t       scan,
	input  logic [31:0] cp,
	output result_t     res
);

	logic [2:0]  ucnt;
	logic [31:0] ubytes;

	always_comb begin
		ucnt   = 3'd0;
		ubytes = 32'd0;
		priority if (cp >= CP_LIMIT) begin
			ucnt   = 3'd0;
			ubytes = 32'd0;
		end else if (cp < CP_2B) begin
			ucnt   = 3'd1;
			ubytes = {25'd0, cp[6:0]};
		end else if (cp < CP_3B) begin
			ucnt   = 3'd2;
			ubytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
		end else if (cp < CP_4B) begin
			ucnt   = 3'd3;
			ubytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
		end else begin
			ucnt   = 3'd4;
			ubytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
		end

		priority if (!scan.found) begin
			res.action    = ACT_LITERAL;
			res.consumed  = 4'd1;
			res.out_count = 3'd0;
			res.out_bytes = 32'd0;
		end else if (scan.numeric) begin
			res.action    = ACT_DECODED;
			res.consumed  = scan.consumed;
			res.out_count = ucnt;
			res.out_bytes = ubytes;
		end else if (scan.name_hit) begin
			res.action    = ACT_DECODED;
			res.consumed  = scan.consumed;
			res.out_count = scan.name_cnt;
			res.out_bytes = {8'd0, scan.name_utf};
		end else begin
			res.action    = ACT_RAW;
			res.consumed  = scan.consumed;
			res.out_count = 3'd0;
			res.out_bytes = 32'd0;
		end
	end

endmodule

// ===== src/html_char_reference_decoder_core.sv =====
// A beat passes stage registers s1, s2, s3 to output register s4; each stage holds one beat.
// Throughput: one beat per clock cycle unless the output stalls; empty stages close up.
// The four stages are classification, two accumulator segments of the numeric code point,
// and UTF-8 encoding into the output register.
// Reset (arst_n low) clears every stage valid bit at once; the payload registers are not reset.
// There is no stored state between beats, so no clearing pass follows reset.
module html_char_reference_decoder_core import htmlcr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// Fields from bit 0: window_low[63:0], window_high[87:64], avail[91:88], zero pad.
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// Fields from bit 0: action[1:0], consumed[5:2], out_count[8:6], out_bytes[40:9], zero pad.
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [63:0] window_low;
	logic [23:0] window_high;
	logic [3:0]  avail;

	scan_t       scan_c;
	scan_t       scan_s1;
	scan_t       scan_s2;
	scan_t       scan_s3;
	logic [31:0] acc_c2;
	logic [31:0] acc_c3;
	logic [31:0] acc_s2;
	logic [31:0] acc_s3;
	result_t     res_c4;
	result_t     res_s4;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic en1;
	logic en2;
	logic en3;
	logic en4;

	assign window_low  = s_axis_tdata[63:0];
	assign window_high = s_axis_tdata[87:64];
	assign avail       = s_axis_tdata[91:88];

	// A stage may load when it is empty or when its contents move on in the same cycle.
	// The chain lets a beat enter while a finished result still waits at the output.
	assign en4 = !valid_s4 || m_axis_tready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign s_axis_tready = en1;
	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {7'd0, res_s4.out_bytes, res_s4.out_count, res_s4.consumed,
		res_s4.action};

	// Stage one: find the closing semicolon, classify digits and match the named references.
	htmlcr_scan u_scan (
		.window_low  (window_low),
		.window_high (window_high),
		.avail       (avail),
		.scan        (scan_c)
	);

	// Stage two: digits at window positions two to six.
	htmlcr_accum u_accum_lo (
		.hex     (scan_s1.hex),
		.acc_in  (32'd0),
		.digits  (scan_s1.digits[SEG_DIGITS-1:0]),
		.active  (scan_s1.active[SEG_DIGITS-1:0]),
		.acc_out (acc_c2)
	);

	// Stage three: digits at window positions seven to ten; the fifth slot is unused.
	htmlcr_accum u_accum_hi (
		.hex     (scan_s2.hex),
		.acc_in  (acc_s2),
		.digits  ({4'd0, scan_s2.digits[NUM_DIGITS-1:SEG_DIGITS]}),
		.active  ({1'b0, scan_s2.active[NUM_DIGITS-1:SEG_DIGITS]}),
		.acc_out (acc_c3)
	);

	// Stage four: UTF-8 encoding and choice between literal, decoded and raw results.
	htmlcr_encode u_encode (
		.scan (scan_s3),
		.cp   (acc_s3),
		.res  (res_c4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			scan_s1 <= scan_c;
		end
		if (en2) begin
			scan_s2 <= scan_s1;
			acc_s2  <= acc_c2;
		end
		if (en3) begin
			scan_s3 <= scan_s2;
			acc_s3  <= acc_c3;
		end
		if (en4) begin
			res_s4 <= res_c4;
		end
	end

	// A code point at or above the limit needs at least six hex or seven decimal digits,
	// so the reference runs to at least ten bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && (res_s4.action == ACT_DECODED) && (res_s4.out_count == 3'd0))
		|-> (res_s4.consumed >= 4'd10))
		else $error("empty decode from a short reference");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && (res_s4.action == ACT_LITERAL))
		|-> ((res_s4.consumed == 4'd1) && (res_s4.out_count == 3'd0)))
		else $error("literal ampersand with wrong length");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && (res_s4.action == ACT_RAW))
		|-> ((res_s4.out_count == 3'd0) && (res_s4.consumed >= 4'd2)))
		else $error("raw name result carries bytes");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while the pipeline is full and stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s4) |-> $past(valid_s3))
		else $error("output became valid without a beat in stage three");

endmodule
